>>> hdl/virtqueue_descriptor_manager_unit_defines.svh
// Assertion macros for the descriptor manager checker.
`ifndef VIRTQUEUE_DESCRIPTOR_MANAGER_UNIT_DEFINES_SVH
`define VIRTQUEUE_DESCRIPTOR_MANAGER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, held off during reset.
`define VQDM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, held off during reset.
`define VQDM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/vqdm_pkg.sv
// Types and constants shared by the virtqueue descriptor manager.
package vqdm_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_WALK_RD,
    ST_WALK_UPD,
    ST_FINAL
  } state_t;

  localparam logic [2:0] KIND_DESC   = 3'd0;
  localparam logic [2:0] KIND_AVAIL  = 3'd1;
  localparam logic [2:0] KIND_DONE   = 3'd2;
  localparam logic [2:0] KIND_ERR    = 3'd3;
  localparam logic [2:0] KIND_NOFREE = 3'd4;

  localparam logic [1:0] FLAG_NONE  = 2'b00;
  localparam logic [1:0] FLAG_NEXT  = 2'b01;
  localparam logic [1:0] FLAG_WRITE = 2'b10;

  localparam logic [1:0] EMIT_HDR   = 2'd0;
  localparam logic [1:0] EMIT_DATA  = 2'd1;
  localparam logic [1:0] EMIT_STS   = 2'd2;
  localparam logic [1:0] EMIT_AVAIL = 2'd3;

  localparam logic [1:0] CFG_HEADER_BASE  = 2'd0;
  localparam logic [1:0] CFG_STATUS_BASE  = 2'd1;
  localparam logic [1:0] CFG_SECTOR_BYTES = 2'd2;

  localparam logic [12:0] HDR_LEN        = 13'd16;
  localparam logic [12:0] STS_LEN        = 13'd1;
  localparam logic [12:0] SECTOR_DEFAULT = 13'd512;
  localparam logic [7:0]  STATUS_OK      = 8'h00;
  localparam logic [1:0]  LAST_TAKE      = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [31:0] lba;
    logic [47:0] data_addr;
    logic        is_write;
    logic [2:0]  used_head;
    logic [7:0]  dev_status;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  slot;
    logic [47:0] buf_addr;
    logic [12:0] byte_len;
    logic [1:0]  desc_flags;
    logic [2:0]  next_slot;
    logic        req_type;
    logic [31:0] sector_out;
    logic [15:0] ring_pos;
    logic        last;
  } out_t;

  typedef struct packed {
    logic clear;
    logic run;
  } scan_ctl_t;

  typedef struct packed {
    logic hit;
    logic empty;
  } scan_res_t;

endpackage

>>> hdl/virtqueue_descriptor_manager_unit.sv
// Split virtqueue descriptor manager for block requests: sequencer, free map and result port.
//
// One transaction is worked at a time; in_stall is high from acceptance until the
// sequencer has loaded the transaction's final result into the output register. A submit
// is accepted, then takes three slots in the free-slot finder (one slot found per cycle,
// one 8-slot chunk of the free map examined per cycle, NCHUNK = SLOTS/8 rounded up), then
// emits header, data, status and avail results, one per cycle while out_stall stays low,
// writing the header, data and status links into the chain memory. A submit with fewer
// than three free slots releases what it took and ends in one "no free" result. A
// successful completion is accepted, then walks the chain with a memory read and then a
// free per slot, then gives its result. A failed completion goes from acceptance
// straight to its error result.
module virtqueue_descriptor_manager_unit import vqdm_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int STEP_W = $clog2(SLOTS + 1);
  localparam int RAM_W  = IDX_W + 2;
  localparam logic [8:0] SLOTS_V = 9'(SLOTS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SLOTS - 1);

  state_t             state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;
  logic [47:0]        hdr_base_r, hdr_base_nxt;
  logic [47:0]        sts_base_r, sts_base_nxt;
  logic [12:0]        sec_bytes_r, sec_bytes_nxt;
  logic [SLOTS-1:0]   free_map_r, free_map_nxt;
  logic [SLOTS-1:0]   in_flight_r, in_flight_nxt;
  logic [15:0]        avail_idx_r, avail_idx_nxt;
  logic [15:0]        used_idx_r, used_idx_nxt;
  logic [IDX_W-1:0]   idx_r [3];
  logic [IDX_W-1:0]   idx_nxt [3];
  logic [1:0]         got_r, got_nxt;
  logic [1:0]         emit_r, emit_nxt;
  logic [IDX_W-1:0]   cur_r, cur_nxt;
  logic [STEP_W-1:0]  steps_r, steps_nxt;
  logic [31:0]        lba_r, lba_nxt;
  logic [47:0]        data_addr_r, data_addr_nxt;
  logic               is_write_r, is_write_nxt;
  logic [2:0]         res_kind_r, res_kind_nxt;
  logic [2:0]         res_slot_r, res_slot_nxt;

  scan_ctl_t          scan_ctl;
  scan_res_t          scan_res;
  logic [IDX_W-1:0]   scan_idx;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [RAM_W-1:0]   ram_wdata;
  logic [RAM_W-1:0]   ram_rdata;
  logic [1:0]         rd_flags;
  logic [IDX_W-1:0]   rd_next;

  logic               out_free;
  logic               head_ok;
  logic               cur_ok;
  logic [IDX_W-1:0]   head_idx;
  out_t               res;

  vqdm_free_scan #(.SLOTS(SLOTS)) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .free_map (free_map_r),
    .ctl      (scan_ctl),
    .res      (scan_res),
    .idx      (scan_idx)
  );

  vqdm_chain_ram #(.DEPTH(SLOTS), .WIDTH(RAM_W)) u_chain (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cur_r),
    .rdata (ram_rdata)
  );

  assign rd_flags  = ram_rdata[RAM_W-1 -: 2];
  assign rd_next   = ram_rdata[IDX_W-1:0];
  assign out_free  = !out_valid_r || !out_stall;
  assign head_ok   = 9'(in_data.used_head) < SLOTS_V;
  assign head_idx  = IDX_W'(in_data.used_head);
  assign cur_ok    = 9'(cur_r) < SLOTS_V;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    hdr_base_nxt  = hdr_base_r;
    sts_base_nxt  = sts_base_r;
    sec_bytes_nxt = sec_bytes_r;
    free_map_nxt  = free_map_r;
    in_flight_nxt = in_flight_r;
    avail_idx_nxt = avail_idx_r;
    used_idx_nxt  = used_idx_r;
    idx_nxt       = idx_r;
    got_nxt       = got_r;
    emit_nxt      = emit_r;
    cur_nxt       = cur_r;
    steps_nxt     = steps_r;
    lba_nxt       = lba_r;
    data_addr_nxt = data_addr_r;
    is_write_nxt  = is_write_r;
    res_kind_nxt  = res_kind_r;
    res_slot_nxt  = res_slot_r;
    scan_ctl      = '0;
    ram_we        = 1'b0;
    ram_waddr     = idx_r[0];
    ram_wdata     = '0;
    res           = '0;

    if (cfg_we) begin
      case (cfg_index)
        CFG_HEADER_BASE:  hdr_base_nxt  = cfg_data;
        CFG_STATUS_BASE:  sts_base_nxt  = cfg_data;
        CFG_SECTOR_BYTES: sec_bytes_nxt = cfg_data[12:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (!in_data.mode) begin
            lba_nxt        = in_data.lba;
            data_addr_nxt  = in_data.data_addr;
            is_write_nxt   = in_data.is_write;
            got_nxt        = '0;
            scan_ctl.clear = 1'b1;
            state_nxt      = ST_SCAN;
          end else begin
            res_slot_nxt = in_data.used_head;
            if (!head_ok || !in_flight_r[head_idx] || in_data.dev_status != STATUS_OK) begin
              res_kind_nxt = KIND_ERR;
              state_nxt    = ST_FINAL;
            end else begin
              cur_nxt   = head_idx;
              steps_nxt = '0;
              state_nxt = ST_WALK_RD;
            end
          end
        end
      end

      ST_SCAN: begin
        scan_ctl.run = 1'b1;
        if (scan_res.hit) begin
          free_map_nxt[scan_idx] = 1'b0;
          idx_nxt[got_r]         = scan_idx;
          if (got_r == LAST_TAKE) begin
            emit_nxt  = EMIT_HDR;
            state_nxt = ST_EMIT;
          end else begin
            got_nxt = got_r + 2'd1;
          end
        end else if (scan_res.empty) begin
          // Give back the slots taken so far.
          for (int i = 0; i < 3; i++) begin
            if (2'(i) < got_r) begin
              free_map_nxt[idx_r[i]] = 1'b1;
            end
          end
          res_kind_nxt = KIND_NOFREE;
          res_slot_nxt = '0;
          state_nxt    = ST_FINAL;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          emit_nxt      = emit_r + 2'd1;
          case (emit_r)
            EMIT_HDR: begin
              res.kind       = KIND_DESC;
              res.slot       = 3'(idx_r[0]);
              res.buf_addr   = hdr_base_r + 48'({idx_r[0], 4'b0000});
              res.byte_len   = HDR_LEN;
              res.desc_flags = FLAG_NEXT;
              res.next_slot  = 3'(idx_r[1]);
              res.req_type   = is_write_r;
              res.sector_out = lba_r;
              ram_we         = 1'b1;
              ram_waddr      = idx_r[0];
              ram_wdata      = {FLAG_NEXT, idx_r[1]};
            end
            EMIT_DATA: begin
              res.kind       = KIND_DESC;
              res.slot       = 3'(idx_r[1]);
              res.buf_addr   = data_addr_r;
              res.byte_len   = sec_bytes_r;
              res.desc_flags = FLAG_NEXT | (is_write_r ? FLAG_NONE : FLAG_WRITE);
              res.next_slot  = 3'(idx_r[2]);
              ram_we         = 1'b1;
              ram_waddr      = idx_r[1];
              ram_wdata      = {res.desc_flags, idx_r[2]};
            end
            EMIT_STS: begin
              res.kind       = KIND_DESC;
              res.slot       = 3'(idx_r[2]);
              res.buf_addr   = sts_base_r + 48'(idx_r[0]);
              res.byte_len   = STS_LEN;
              res.desc_flags = FLAG_WRITE;
              ram_we         = 1'b1;
              ram_waddr      = idx_r[2];
              ram_wdata      = {FLAG_WRITE, {IDX_W{1'b0}}};
            end
            EMIT_AVAIL: begin
              res.kind                = KIND_AVAIL;
              res.slot                = 3'(idx_r[0]);
              res.ring_pos            = avail_idx_r;
              res.last                = 1'b1;
              avail_idx_nxt           = avail_idx_r + 16'd1;
              in_flight_nxt[idx_r[0]] = 1'b1;
              state_nxt               = ST_IDLE;
            end
            default: ;
          endcase
          out_data_nxt = res;
        end
      end

      ST_WALK_RD: begin
        // Stop at a slot that is already free or out of range.
        if (!cur_ok || free_map_r[cur_r]) begin
          used_idx_nxt = used_idx_r + 16'd1;
          res_kind_nxt = KIND_DONE;
          state_nxt    = ST_FINAL;
        end else begin
          state_nxt = ST_WALK_UPD;
        end
      end

      ST_WALK_UPD: begin
        free_map_nxt[cur_r]  = 1'b1;
        in_flight_nxt[cur_r] = 1'b0;
        if (!rd_flags[0] || steps_r == STEP_LAST) begin
          used_idx_nxt = used_idx_r + 16'd1;
          res_kind_nxt = KIND_DONE;
          state_nxt    = ST_FINAL;
        end else begin
          cur_nxt   = rd_next;
          steps_nxt = steps_r + STEP_W'(1);
          state_nxt = ST_WALK_RD;
        end
      end

      ST_FINAL: begin
        if (out_free) begin
          res.kind      = res_kind_r;
          res.slot      = res_slot_r;
          res.last      = 1'b1;
          out_data_nxt  = res;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      hdr_base_r  <= '0;
      sts_base_r  <= '0;
      sec_bytes_r <= SECTOR_DEFAULT;
      free_map_r  <= '1;
      in_flight_r <= '0;
      avail_idx_r <= '0;
      used_idx_r  <= '0;
      got_r       <= '0;
      emit_r      <= EMIT_HDR;
      steps_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hdr_base_r  <= hdr_base_nxt;
      sts_base_r  <= sts_base_nxt;
      sec_bytes_r <= sec_bytes_nxt;
      free_map_r  <= free_map_nxt;
      in_flight_r <= in_flight_nxt;
      avail_idx_r <= avail_idx_nxt;
      used_idx_r  <= used_idx_nxt;
      got_r       <= got_nxt;
      emit_r      <= emit_nxt;
      steps_r     <= steps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    idx_r       <= idx_nxt;
    cur_r       <= cur_nxt;
    lba_r       <= lba_nxt;
    data_addr_r <= data_addr_nxt;
    is_write_r  <= is_write_nxt;
    res_kind_r  <= res_kind_nxt;
    res_slot_r  <= res_slot_nxt;
  end

endmodule

>>> hdl/vqdm_chain_ram.sv
// Chain link memory: flags and next slot per descriptor, registered read.
module vqdm_chain_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 5
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/vqdm_free_scan.sv
// Free slot finder: one free_map chunk per cycle on run, lowest set bit first.
module vqdm_free_scan import vqdm_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [SLOTS-1:0]         free_map,
  input  scan_ctl_t                ctl,
  output scan_res_t                res,
  output logic [$clog2(SLOTS)-1:0] idx
);

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CHUNK  = (SLOTS < 8) ? SLOTS : 8;
  localparam int NCHUNK = (SLOTS + CHUNK - 1) / CHUNK;
  localparam int CUR_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int CH_W   = $clog2(CHUNK);
  localparam int PAD    = NCHUNK * CHUNK;
  localparam logic [CUR_W-1:0] LAST_CUR = CUR_W'(NCHUNK - 1);

  logic [CUR_W-1:0] cursor_r, cursor_nxt;
  logic [PAD-1:0]   padded;
  logic [CHUNK-1:0] chunk;
  logic [CH_W-1:0]  pos;
  logic             hit;

  assign padded = PAD'(free_map);
  assign chunk  = padded[cursor_r*CHUNK +: CHUNK];
  assign hit    = |chunk;

  // Walk down so the lowest set bit wins.
  always_comb begin
    pos = '0;
    for (int i = CHUNK - 1; i >= 0; i--) begin
      if (chunk[i]) begin
        pos = CH_W'(i);
      end
    end
  end

  assign idx       = IDX_W'(int'(cursor_r) * CHUNK + int'(pos));
  assign res.hit   = hit;
  assign res.empty = !hit && (cursor_r == LAST_CUR);

  always_comb begin
    cursor_nxt = cursor_r;
    if (ctl.clear) begin
      cursor_nxt = '0;
    end else if (ctl.run && !hit && cursor_r != LAST_CUR) begin
      cursor_nxt = cursor_r + CUR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
    end else begin
      cursor_r <= cursor_nxt;
    end
  end

endmodule

>>> hdl/vqdm_checker.sv
// Port-level checker for the descriptor manager, bound to the top level.
`include "virtqueue_descriptor_manager_unit_defines.svh"

module vqdm_checker import vqdm_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  `VQDM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `VQDM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input not held off after a transaction")
  `VQDM_ASSERT_SAME(a_busy_mid_item, out_valid && !out_data.last, in_stall, "new transaction accepted mid item")
  `VQDM_ASSERT_SAME(a_last_kind, out_valid && out_data.kind != KIND_DESC, out_data.last, "non-descriptor result without last")

endmodule

bind virtqueue_descriptor_manager_unit vqdm_checker u_vqdm_checker (.*);

>>> bench/vqdm_ring_checker.sv
// Ring checker for the descriptor manager: tracks slot state, predicts results, compares them.
module vqdm_ring_checker import vqdm_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_t        out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  output int          fail_count,
  output int          pending_count
);

  logic [SLOTS-1:0] slot_free;
  logic [SLOTS-1:0] head_busy;
  logic [1:0]       link_flags [SLOTS];
  logic [2:0]       link_next  [SLOTS];
  logic [15:0]      avail_pos;
  logic [15:0]      used_pos;
  logic [47:0]      hdr_base;
  logic [47:0]      sts_base;
  logic [12:0]      data_len;
  out_t             ring_results_due [$];

  function automatic out_t bare_result(input logic [2:0] kind, input logic [2:0] slot,
                                       input logic last);
    out_t r;
    r = '0;
    r.kind = kind;
    r.slot = slot;
    r.last = last;
    return r;
  endfunction

  task automatic predict_ring_writes(input in_t req);
    int         picked [3];
    int         got;
    int         i;
    int         cur;
    int         steps;
    logic       walking;
    logic [1:0] fl;
    logic [2:0] nx;
    out_t       r;
    got = 0;
    if (req.mode == 1'b0) begin
      for (i = 0; i < SLOTS; i++) begin
        if (slot_free[i] && got < 3) begin
          picked[got] = i;
          got++;
        end
      end
      if (got < 3) begin
        ring_results_due.push_back(bare_result(KIND_NOFREE, 3'd0, 1'b1));
      end else begin
        for (i = 0; i < 3; i++) slot_free[picked[i]] = 1'b0;
        link_flags[picked[0]] = FLAG_NEXT;
        link_next[picked[0]]  = 3'(picked[1]);
        link_flags[picked[1]] = (req.is_write ? FLAG_NONE : FLAG_WRITE) | FLAG_NEXT;
        link_next[picked[1]]  = 3'(picked[2]);
        link_flags[picked[2]] = FLAG_WRITE;
        link_next[picked[2]]  = 3'd0;
        head_busy[picked[0]]  = 1'b1;

        r = bare_result(KIND_DESC, 3'(picked[0]), 1'b0);
        r.buf_addr   = hdr_base + 48'(16 * picked[0]);
        r.byte_len   = HDR_LEN;
        r.desc_flags = link_flags[picked[0]];
        r.next_slot  = 3'(picked[1]);
        r.req_type   = req.is_write;
        r.sector_out = req.lba;
        ring_results_due.push_back(r);

        r = bare_result(KIND_DESC, 3'(picked[1]), 1'b0);
        r.buf_addr   = req.data_addr;
        r.byte_len   = data_len;
        r.desc_flags = link_flags[picked[1]];
        r.next_slot  = 3'(picked[2]);
        ring_results_due.push_back(r);

        r = bare_result(KIND_DESC, 3'(picked[2]), 1'b0);
        r.buf_addr   = sts_base + 48'(picked[0]);
        r.byte_len   = STS_LEN;
        r.desc_flags = link_flags[picked[2]];
        ring_results_due.push_back(r);

        r = bare_result(KIND_AVAIL, 3'(picked[0]), 1'b1);
        r.ring_pos = avail_pos;
        ring_results_due.push_back(r);
        avail_pos++;
      end
    end else if (int'(req.used_head) >= SLOTS || !head_busy[req.used_head] ||
                 req.dev_status != STATUS_OK) begin
      ring_results_due.push_back(bare_result(KIND_ERR, req.used_head, 1'b1));
    end else begin
      // walk the chain from the head; stop on a free or out-of-range slot or a descriptor without NEXT
      cur = int'(req.used_head);
      walking = 1'b1;
      for (steps = 0; steps < SLOTS && walking; steps++) begin
        if (cur >= SLOTS || slot_free[cur]) begin
          walking = 1'b0;
        end else begin
          fl = link_flags[cur];
          nx = link_next[cur];
          slot_free[cur]  = 1'b1;
          head_busy[cur]  = 1'b0;
          link_flags[cur] = FLAG_NONE;
          link_next[cur]  = 3'd0;
          if ((fl & FLAG_NEXT) == FLAG_NONE) walking = 1'b0;
          else cur = int'(nx);
        end
      end
      used_pos++;
      ring_results_due.push_back(bare_result(KIND_DONE, req.used_head, 1'b1));
    end
  endtask

  task automatic check_field(input string name, input logic [47:0] want,
                             input logic [47:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic compare_result(input out_t got);
    out_t want;
    if (ring_results_due.size() == 0) begin
      $display("%0t: result with none expected, actual %h", $time, got);
      fail_count++;
    end else begin
      want = ring_results_due.pop_front();
      check_field("kind", 48'(want.kind), 48'(got.kind));
      check_field("slot", 48'(want.slot), 48'(got.slot));
      check_field("buf_addr", want.buf_addr, got.buf_addr);
      check_field("byte_len", 48'(want.byte_len), 48'(got.byte_len));
      check_field("desc_flags", 48'(want.desc_flags), 48'(got.desc_flags));
      check_field("next_slot", 48'(want.next_slot), 48'(got.next_slot));
      check_field("req_type", 48'(want.req_type), 48'(got.req_type));
      check_field("sector_out", 48'(want.sector_out), 48'(got.sector_out));
      check_field("ring_pos", 48'(want.ring_pos), 48'(got.ring_pos));
      check_field("last", 48'(want.last), 48'(got.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      slot_free = '1;
      head_busy = '0;
      for (int i = 0; i < SLOTS; i++) begin
        link_flags[i] = FLAG_NONE;
        link_next[i]  = 3'd0;
      end
      avail_pos = '0;
      used_pos  = '0;
      hdr_base  = '0;
      sts_base  = '0;
      data_len  = SECTOR_DEFAULT;
      ring_results_due.delete();
      fail_count    = 0;
      pending_count = 0;
    end else begin
      if (out_valid && !out_stall) compare_result(out_data);
      if (cfg_we) begin
        case (cfg_index)
          CFG_HEADER_BASE:  hdr_base = cfg_data;
          CFG_STATUS_BASE:  sts_base = cfg_data;
          CFG_SECTOR_BYTES: data_len = cfg_data[12:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_ring_writes(in_data);
      pending_count = ring_results_due.size();
    end
  end

endmodule

>>> bench/tb_virtqueue_descriptor_manager_unit.sv
// Testbench top for the descriptor manager: clock, reset, stimulus, stalls and verdict.
module tb_virtqueue_descriptor_manager_unit;
  import vqdm_pkg::*;

  localparam int          SLOTS         = 8;
  localparam int          CYCLE_LIMIT   = 200000;
  localparam int          LONG_HOLD     = 300;
  localparam int          DRAIN_CYCLES  = 20;
  localparam logic [1:0]  CFG_SPARE     = 2'd3;
  localparam logic        MODE_SUBMIT   = 1'b0;
  localparam logic        MODE_COMPLETE = 1'b1;
  localparam logic [2:0]  HEAD_LOW      = 3'd0;
  localparam logic [2:0]  HEAD_HIGH     = 3'd3;
  localparam logic [47:0] ADDR_MAX      = '1;
  localparam logic [31:0] LBA_MAX       = '1;
  localparam logic [7:0]  STATUS_MAX    = 8'hff;
  localparam logic [7:0]  STATUS_ONE    = 8'h01;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_t         in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [47:0] cfg_data  = '0;
  int          fail_count;
  int          pending_count;
  int          cycle_count = 0;
  bit          steady = 1'b0;
  bit          hold_requested = 1'b0;

  virtqueue_descriptor_manager_unit #(.SLOTS(SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  vqdm_ring_checker #(.SLOTS(SLOTS)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [47:0] random_word();
    return {16'($urandom_range(0, 65535)), 32'($urandom)};
  endfunction

  function automatic in_t submit_req(input logic [31:0] lba, input logic [47:0] addr,
                                     input logic wr);
    in_t req;
    req = '0;
    req.mode      = MODE_SUBMIT;
    req.lba       = lba;
    req.data_addr = addr;
    req.is_write  = wr;
    return req;
  endfunction

  function automatic in_t complete_req(input logic [2:0] head, input logic [7:0] status);
    in_t req;
    req = '0;
    req.mode       = MODE_COMPLETE;
    req.used_head  = head;
    req.dev_status = status;
    return req;
  endfunction

  function automatic in_t random_request();
    in_t req;
    int  pick;
    req.mode       = MODE_SUBMIT;
    req.lba        = $urandom;
    req.data_addr  = random_word();
    req.is_write   = 1'($urandom_range(0, 1));
    req.used_head  = 3'($urandom_range(0, 7));
    req.dev_status = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick >= 45) begin
      req.mode = MODE_COMPLETE;
      // chains always occupy slots 0-2 or 3-5, so a live head is one of two
      if (pick < 85) begin
        req.used_head  = $urandom_range(0, 1) ? HEAD_HIGH : HEAD_LOW;
        req.dev_status = ($urandom_range(0, 9) < 7) ? STATUS_OK
                                                    : 8'($urandom_range(1, 255));
      end
    end
    return req;
  endfunction

  task automatic send_item(input in_t req);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid and hold until every expected result has been taken
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [47:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [47:0] hb, input logic [47:0] sb,
                           input logic [47:0] sector_word, input int count,
                           input bit quiet, input bit hold);
    settle();
    steady = quiet;
    write_reg(CFG_HEADER_BASE, hb);
    write_reg(CFG_STATUS_BASE, sb);
    write_reg(CFG_SECTOR_BYTES, sector_word);
    write_reg(CFG_SPARE, random_word());
    cfg_we <= 1'b0;
    if (hold) hold_requested = 1'b1;
    repeat (count) send_item(random_request());
  endtask

  initial begin : result_sink
    int gap;
    forever begin
      if (hold_requested) begin
        hold_requested = 1'b0;
        gap = LONG_HOLD;
      end else begin
        gap = steady ? 0 : $urandom_range(0, 10);
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_item(submit_req('0, '0, 1'b0));
    send_item(submit_req(LBA_MAX, ADDR_MAX, 1'b1));
    send_item(submit_req(32'h0000_1234, 48'h1234_5678_9abc, 1'b0));   // no room left
    send_item(complete_req(HEAD_LOW, STATUS_MAX));
    send_item(complete_req(3'd1, STATUS_OK));                          // middle of a chain
    send_item(complete_req(3'd7, STATUS_OK));                          // free slot
    send_item(complete_req(HEAD_LOW, STATUS_OK));
    send_item(complete_req(HEAD_LOW, STATUS_OK));                      // already retired
    send_item(submit_req(32'h8000_0000, 48'h8000_0000_0000, 1'b1));
    send_item(complete_req(HEAD_HIGH, STATUS_ONE));
    send_item(complete_req(HEAD_HIGH, STATUS_OK));
    send_item(submit_req(32'h5555_aaaa, 48'haaaa_5555_aaaa, 1'b0));
    send_item(submit_req(32'h0000_0001, 48'h0000_0000_0001, 1'b1));
    send_item(complete_req(HEAD_LOW, STATUS_OK));
    send_item(complete_req(HEAD_HIGH, STATUS_OK));
    send_item(complete_req(HEAD_HIGH, STATUS_MAX));
    send_item(submit_req(LBA_MAX, '0, 1'b1));
    send_item(complete_req(3'd2, STATUS_MAX));
    send_item(complete_req(HEAD_LOW, STATUS_OK));

    run_phase(ADDR_MAX, ADDR_MAX, 48'd0, 60, 1'b1, 1'b0);
    run_phase(random_word(), random_word(), 48'd4096, 60, 1'b0, 1'b1);
    run_phase('0, '0, random_word() | 48'h1fff, 60, 1'b0, 1'b0);
    run_phase(random_word(), random_word(), 48'd1, 55, 1'b0, 1'b0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/vqdm_pkg.sv
hdl/vqdm_chain_ram.sv
hdl/vqdm_free_scan.sv
hdl/virtqueue_descriptor_manager_unit.sv
hdl/vqdm_checker.sv
bench/vqdm_ring_checker.sv
bench/tb_virtqueue_descriptor_manager_unit.sv
